>>> design/pidc_pkg.sv
// Shared widths, register codes and types of the clamped PID controller.
package pidc_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int ERR_W     = 32;
    localparam int KP_W      = 23;
    localparam int GAIN_W    = 20;
    localparam int DT_W      = 20;
    localparam int LIM_W     = 20;
    localparam int INTEG_W   = LIM_W + 1;
    localparam int DERIV_W   = LIM_W + 1;

    // Shared multiplier: signed operand times unsigned operand.
    localparam int MUL_A_W = ERR_W + 1;
    localparam int MUL_B_W = KP_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    // Divider: magnitude of the error difference scaled by the fraction bits.
    localparam int DIFF_W    = ERR_W + 1;
    localparam int DIVQ_W    = DIFF_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVQ_W + 1);

    // Register port.
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_LIMIT = 3'd5;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic              busy;
        logic [DIVQ_W-1:0] quo;
    } t_div_stat;

endpackage

>>> design/pidc_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module pidc_mul (
    input  logic                                 i_clk,
    input  logic signed [pidc_pkg::MUL_A_W-1:0]  i_a,
    input  logic        [pidc_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [pidc_pkg::PROD_W-1:0]   o_prod
);
    import pidc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * $signed({1'b0, i_b});
    end

    assign o_prod = r_prod;

endmodule

>>> design/pidc_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module pidc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pidc_pkg::DIVQ_W-1:0]   i_dividend,
    input  logic [pidc_pkg::DT_W-1:0]     i_divisor,
    output pidc_pkg::t_div_stat           o_stat
);
    import pidc_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVQ_W-1:0]    r_quo;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_dvs;
    logic [DT_W:0]        w_trial;
    logic                 w_fit;

    // The partial remainder stays below the divisor, so the trial needs one extra bit.
    assign w_trial = {r_rem, r_quo[DIVQ_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIVQ_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIVQ_W-2:0], w_fit};
            r_rem <= w_fit ? DT_W'(w_trial - {1'b0, r_dvs}) : w_trial[DT_W-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.quo  = r_quo;

endmodule

>>> design/pid_controller_clamped.sv
// Clamped discrete PID controller: register port, sequencer and state.
// The derivative is formed by the bit-serial divider, one quotient bit per cycle.
// A new error is accepted only once the previous one has left the sequencer.
// The block takes a new error while a finished result still waits in the output register.
// Reset (synchronous, active low) clears registers, integral and previous error.
module pid_controller_clamped (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidc_pkg::DATA_W-1:0]        pwdata,
    output logic [pidc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // Error input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [pidc_pkg::ERR_W-1:0]  i_error_in,
    // Drive output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pidc_pkg::ERR_W-1:0]  o_drive_out,
    output logic                               o_out_saturated
);
    import pidc_pkg::*;

    // Sequencer states. Each multiply is issued in one state and its product
    // is consumed in the next, since the shared multiplier registers its output.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MDT,
        S_MKP,
        S_MKI,
        S_ACCI,
        S_WDIV,
        S_MKD,
        S_ACCD,
        S_FIN
    } t_state;

    // Configuration registers.
    logic [KP_W-1:0]   r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_deriv_gain;
    logic [DT_W-1:0]   r_step_period;
    logic [LIM_W-1:0]  r_integ_limit;
    logic [LIM_W-1:0]  r_deriv_limit;

    // Controller state kept between transactions.
    logic signed [INTEG_W-1:0] r_integ_acc;
    logic signed [ERR_W-1:0]   r_prev_error;

    // Working registers of one transaction.
    t_state                    r_state;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_diff_neg;
    logic                      r_diff_zero;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [PROD_W-1:0]  r_sum;
    logic                      r_out_valid;
    logic signed [ERR_W-1:0]   r_drive_out;
    logic                      r_out_sat;

    logic                      w_in_acc;
    logic                      w_cfg_wr;
    logic [REG_IDX_W-1:0]      w_reg_idx;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         w_diff_mag;
    logic [DIVQ_W-1:0]         w_dividend;
    t_div_stat                 w_div;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0]        w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_integ_sum;
    logic signed [PROD_W-1:0]  w_integ_lim;
    logic signed [INTEG_W-1:0] w_integ_clamp;
    logic [LIM_W-1:0]          w_deriv_mag;
    logic signed [DERIV_W-1:0] w_deriv;
    logic signed [PROD_W-1:0]  w_y;
    logic                      w_sat_hi;
    logic                      w_sat_lo;
    logic signed [ERR_W-1:0]   w_y_sat;
    logic                      w_out_free;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; pready is tied
    // high, so no transaction is ever stretched. Indexes past the last
    // register are ignored on write and read back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_step_period <= '0;
            r_integ_limit <= '0;
            r_deriv_limit <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_PROP_GAIN:   r_prop_gain   <= pwdata[KP_W-1:0];
                REG_INTEG_GAIN:  r_integ_gain  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_deriv_gain  <= pwdata[GAIN_W-1:0];
                REG_STEP_PERIOD: r_step_period <= pwdata[DT_W-1:0];
                REG_INTEG_LIMIT: r_integ_limit <= pwdata[LIM_W-1:0];
                REG_DERIV_LIMIT: r_deriv_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_PROP_GAIN:   prdata = DATA_W'(r_prop_gain);
            REG_INTEG_GAIN:  prdata = DATA_W'(r_integ_gain);
            REG_DERIV_GAIN:  prdata = DATA_W'(r_deriv_gain);
            REG_STEP_PERIOD: prdata = DATA_W'(r_step_period);
            REG_INTEG_LIMIT: prdata = DATA_W'(r_integ_limit);
            REG_DERIV_LIMIT: prdata = DATA_W'(r_deriv_limit);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Derivative divider. It starts on the same edge that accepts the error,
    // dividing |e - prev_error| * 2^FRAC_BITS by the period, and runs while
    // the multiplier works through the proportional and integral terms.
    // With a zero period its quotient is ignored.
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_diff     = DIFF_W'(i_error_in) - DIFF_W'(r_prev_error);
    assign w_diff_mag = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_dividend = {w_diff_mag, {FRAC_BITS{1'b0}}};

    pidc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (w_dividend),
        .i_divisor  (r_step_period),
        .o_stat     (w_div)
    );

    // ------------------------------------------------------------------
    // Shared multiplier. The operand pair is chosen by the current state:
    // e*dt for the integral step, then kp*e, ki*I and kd*D for the output.
    // ------------------------------------------------------------------
    always_comb begin
        case (r_state)
            S_MDT: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(r_step_period);
            end
            S_MKP: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = r_prop_gain;
            end
            S_MKI: begin
                w_mul_a = MUL_A_W'(r_integ);
                w_mul_b = MUL_B_W'(r_integ_gain);
            end
            S_MKD: begin
                w_mul_a = MUL_A_W'(r_deriv);
                w_mul_b = MUL_B_W'(r_deriv_gain);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Integral: the arithmetic shift floors e*dt, then the sum is clamped
    // to the symmetric limit. A zero limit forces the integral to zero.
    assign w_integ_sum = PROD_W'(r_integ_acc) + (w_prod >>> FRAC_BITS);
    assign w_integ_lim = $signed(PROD_W'(r_integ_limit));

    always_comb begin
        if (w_integ_sum > w_integ_lim) begin
            w_integ_clamp = $signed({1'b0, r_integ_limit});
        end else if (w_integ_sum < -w_integ_lim) begin
            w_integ_clamp = -$signed({1'b0, r_integ_limit});
        end else begin
            w_integ_clamp = w_integ_sum[INTEG_W-1:0];
        end
    end

    // Derivative: the quotient magnitude truncates toward zero, so the sign
    // is applied after clamping. A zero period takes the limit by the sign
    // of the difference, or zero when the error did not change.
    always_comb begin
        if (r_step_period == '0) begin
            w_deriv_mag = r_diff_zero ? '0 : r_deriv_limit;
        end else if (w_div.quo > DIVQ_W'(r_deriv_limit)) begin
            w_deriv_mag = r_deriv_limit;
        end else begin
            w_deriv_mag = w_div.quo[LIM_W-1:0];
        end
        w_deriv = r_diff_neg ? -$signed({1'b0, w_deriv_mag}) : $signed({1'b0, w_deriv_mag});
    end

    // Output: floor of the weighted sum, then saturation to 32 bits. The
    // bits above the output's sign bit must all match it.
    assign w_y      = r_sum >>> FRAC_BITS;
    assign w_sat_hi = !w_y[PROD_W-1] && (|w_y[PROD_W-2:ERR_W-1]);
    assign w_sat_lo = w_y[PROD_W-1] && !(&w_y[PROD_W-2:ERR_W-1]);

    always_comb begin
        if (w_sat_hi) begin
            w_y_sat = $signed({1'b0, {(ERR_W-1){1'b1}}});
        end else if (w_sat_lo) begin
            w_y_sat = $signed({1'b1, {(ERR_W-1){1'b0}}});
        end else begin
            w_y_sat = w_y[ERR_W-1:0];
        end
    end

    // The output register can take a new result once the old one is gone
    // or is being taken on this edge.
    assign w_out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Sequencer, controller state and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_integ_acc  <= '0;
            r_prev_error <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // In the final state the output register is reloaded instead.
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_err       <= i_error_in;
                        r_diff_neg  <= w_diff[DIFF_W-1];
                        r_diff_zero <= (w_diff == '0);
                        r_state     <= S_MDT;
                    end
                end
                S_MDT: begin
                    r_state <= S_MKP;
                end
                S_MKP: begin
                    r_integ <= w_integ_clamp;
                    r_state <= S_MKI;
                end
                S_MKI: begin
                    r_sum   <= w_prod;
                    r_state <= S_ACCI;
                end
                S_ACCI: begin
                    r_sum   <= r_sum + w_prod;
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (!w_div.busy) begin
                        r_deriv <= w_deriv;
                        r_state <= S_MKD;
                    end
                end
                S_MKD: begin
                    r_state <= S_ACCD;
                end
                S_ACCD: begin
                    r_sum   <= r_sum + w_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_drive_out  <= w_y_sat;
                        r_out_sat    <= w_sat_hi || w_sat_lo;
                        r_out_valid  <= 1'b1;
                        r_integ_acc  <= r_integ;
                        r_prev_error <= r_err;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_out     = r_drive_out;
    assign o_out_saturated = r_out_sat;

`ifndef ASSERT_OFF
    // Only one transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input accepted while a transaction is in work");

    // The derivative product is only formed after the divider has finished.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MKD) |-> !w_div.busy)
        else $error("derivative used before the divider finished");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> (r_state == S_FIN))
        else $error("result register loaded while still occupied");

    // A saturated result is one of the two extreme values.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_saturated) |->
            (o_drive_out == 32'sh7fffffff || o_drive_out == 32'sh80000000))
        else $error("saturation flag set on a value that is not a bound");
`endif

endmodule

>>> bench/tb_pid_controller_clamped.sv
// Self-checking testbench for the clamped PID controller.
`timescale 1ns / 1ps

module tb_pid_controller_clamped;

    import pidc_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 1000000;
    // A phase change waits for the last result and then lets the bus settle.
    localparam int SETTLE_CYCLES = 8;
    // Cycles after the final result, a little more than the block's latency.
    localparam int TAIL_CYCLES = 64;
    // Length of the single long receiver hold-off that backs up the block.
    localparam int LONG_HOLD = 600;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 322;
    localparam int MAX_SHOWN     = 10;

    // Upper ends of the documented register ranges.
    localparam int unsigned PROP_GAIN_TOP = 6553600;
    localparam int unsigned FRAC_REG_TOP  = 655360;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // Register indexes past the end of the map; writes to them are ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [ERR_W-1:0] drive;
        logic                    sat;
    } t_drive_result;

    typedef enum logic {ROW_WRITE, ROW_ERROR} t_row_kind;

    // One line of the directed table: a register write or an error transaction.
    // Where known is set, the expected result is given in the table itself.
    typedef struct packed {
        t_row_kind               kind;
        logic [REG_IDX_W-1:0]    reg_idx;
        logic [DATA_W-1:0]       value;
        logic                    known;
        logic signed [ERR_W-1:0] exp_drive;
        logic                    exp_sat;
    } t_dir_row;

    function automatic t_dir_row row_write(input logic [REG_IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] val);
        return '{ROW_WRITE, idx, val, 1'b0, '0, 1'b0};
    endfunction

    function automatic t_dir_row row_error(input logic [DATA_W-1:0] val);
        return '{ROW_ERROR, REG_PROP_GAIN, val, 1'b0, '0, 1'b0};
    endfunction

    function automatic t_dir_row row_known(input logic [DATA_W-1:0] val,
                                           input logic [ERR_W-1:0] drive,
                                           input logic sat);
        return '{ROW_ERROR, REG_PROP_GAIN, val, 1'b1, drive, sat};
    endfunction

    localparam int DIR_N = 42;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // Out of reset every gain and limit is zero, so the output is zero.
        row_known(32'h7FFF_FFFF, 32'h0000_0000, 1'b0),
        row_known(32'h8000_0000, 32'h0000_0000, 1'b0),
        row_known(32'h0000_0000, 32'h0000_0000, 1'b0),
        // Top of every range, unit period.
        row_write(REG_PROP_GAIN,   PROP_GAIN_TOP),
        row_write(REG_INTEG_GAIN,  FRAC_REG_TOP),
        row_write(REG_DERIV_GAIN,  FRAC_REG_TOP),
        row_write(REG_STEP_PERIOD, 32'h0001_0000),
        row_write(REG_INTEG_LIMIT, FRAC_REG_TOP),
        row_write(REG_DERIV_LIMIT, FRAC_REG_TOP),
        // A gain of 100 on a full-scale error overflows in both directions.
        row_known(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
        row_known(32'h8000_0000, 32'h8000_0000, 1'b1),
        row_error(32'h0000_0000),
        row_error(32'h0000_0000),
        row_error(32'h0001_0000),
        row_error(32'hFFFF_0000),
        row_error(32'hFFFF_FFFF),
        // Zero period: the derivative takes the limit by the sign of the step.
        row_write(REG_STEP_PERIOD, 32'h0000_0000),
        row_error(32'h0002_8000),
        row_error(32'h0002_8000),
        row_error(32'hFFFD_8000),
        row_write(REG_STEP_PERIOD, FRAC_REG_TOP),
        row_error(32'h1234_5678),
        row_error(32'hEDCB_A988),
        // Zero limits force the integral and the derivative to zero.
        row_write(REG_INTEG_LIMIT, 32'h0000_0000),
        row_write(REG_DERIV_LIMIT, 32'h0000_0000),
        row_error(32'h4000_0000),
        row_error(32'hC000_0000),
        row_write(REG_PROP_GAIN,   32'h0000_0000),
        row_known(32'h7FFF_FFFF, 32'h0000_0000, 1'b0),
        // All ones: bits above each register's width must be dropped.
        row_write(REG_PROP_GAIN,   ALL_ONES),
        row_write(REG_INTEG_GAIN,  ALL_ONES),
        row_write(REG_DERIV_GAIN,  ALL_ONES),
        row_write(REG_STEP_PERIOD, ALL_ONES),
        row_write(REG_INTEG_LIMIT, ALL_ONES),
        row_write(REG_DERIV_LIMIT, ALL_ONES),
        row_write(REG_UNUSED_LO,   32'h0000_FFFF),
        row_write(REG_UNUSED_HI,   ALL_ONES),
        row_error(32'h0000_0001),
        row_known(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
        row_error(32'hFFFF_FFFF),
        row_known(32'h8000_0000, 32'h8000_0000, 1'b1),
        row_error(32'h0000_0000)
    };

    // Block ports.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [ERR_W-1:0] i_error_in;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [ERR_W-1:0] o_drive_out;
    logic                    o_out_saturated;

    // Predictor copy of the registers and the controller state.
    logic [KP_W-1:0]           cfg_prop;
    logic [GAIN_W-1:0]         cfg_integ;
    logic [GAIN_W-1:0]         cfg_deriv;
    logic [DT_W-1:0]           cfg_period;
    logic [LIM_W-1:0]          cfg_integ_lim;
    logic [LIM_W-1:0]          cfg_deriv_lim;
    logic signed [INTEG_W-1:0] integ_state;
    logic signed [ERR_W-1:0]   prev_err_state;

    // Drive results still owed by the block, oldest first.
    t_drive_result drive_expect_q [$];

    int          mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          hold_left    = 0;
    bit          long_hold_go = 1'b0;
    logic signed [ERR_W-1:0] last_err_sent = '0;

    pid_controller_clamped u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_error_in      (i_error_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_out     (o_drive_out),
        .o_out_saturated (o_out_saturated)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Register writes as the block sees them: the value is cut to the
    // register's width and an index past the map changes nothing.
    function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        case (idx)
            REG_PROP_GAIN:   cfg_prop      = val[KP_W-1:0];
            REG_INTEG_GAIN:  cfg_integ     = val[GAIN_W-1:0];
            REG_DERIV_GAIN:  cfg_deriv     = val[GAIN_W-1:0];
            REG_STEP_PERIOD: cfg_period    = val[DT_W-1:0];
            REG_INTEG_LIMIT: cfg_integ_lim = val[LIM_W-1:0];
            REG_DERIV_LIMIT: cfg_deriv_lim = val[LIM_W-1:0];
            default: ;
        endcase
    endfunction

    // One controller step at full precision. The integral term and the sum
    // round toward minus infinity, the derivative quotient toward zero.
    function automatic t_drive_result pid_predict_step(input logic signed [ERR_W-1:0] err);
        longint e, dt, kp, ki, kd, ilim, dlim;
        longint integ, diff, deriv, y;
        t_drive_result res;
        e    = err;
        dt   = cfg_period;
        kp   = cfg_prop;
        ki   = cfg_integ;
        kd   = cfg_deriv;
        ilim = cfg_integ_lim;
        dlim = cfg_deriv_lim;

        integ = longint'(integ_state) + ((e * dt) >>> FRAC_BITS);
        if (integ > ilim) integ = ilim;
        else if (integ < -ilim) integ = -ilim;

        diff = e - longint'(prev_err_state);
        if (dt == 0) begin
            // No period to divide by: only the direction of the step counts.
            if (diff > 0) deriv = dlim;
            else if (diff < 0) deriv = -dlim;
            else deriv = 0;
        end else begin
            deriv = (diff * (longint'(1) <<< FRAC_BITS)) / dt;
            if (deriv > dlim) deriv = dlim;
            else if (deriv < -dlim) deriv = -dlim;
        end

        y = (kp * e + ki * integ + kd * deriv) >>> FRAC_BITS;
        res.sat = 1'b0;
        if (y > DRIVE_MAX) begin
            y = DRIVE_MAX;
            res.sat = 1'b1;
        end else if (y < DRIVE_MIN) begin
            y = DRIVE_MIN;
            res.sat = 1'b1;
        end
        res.drive = y[ERR_W-1:0];

        integ_state    = integ[INTEG_W-1:0];
        prev_err_state = err;
        return res;
    endfunction

    // Register values for a random phase: mostly inside the documented
    // range, with zero, the top and raw 32-bit words mixed in.
    function automatic logic [DATA_W-1:0] pick_reg_value(input int unsigned top);
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = '0;
            2, 3:    v = top;
            4:       v = $urandom;
            5:       v = $urandom_range(1, 255);
            default: v = $urandom_range(0, top);
        endcase
        return v;
    endfunction

    // Error samples for the random part. Most are small or follow the last
    // sample, so that the integral moves in and out of its clamp and the
    // derivative stays inside its limit; the rest cover the full range.
    function automatic logic signed [ERR_W-1:0] next_error_sample();
        logic signed [ERR_W-1:0] v;
        logic signed [ERR_W-1:0] delta;
        delta = $urandom_range(0, 32'h0003_FFFF);
        if ($urandom_range(0, 1) == 1) delta = -delta;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
                v = $urandom_range(0, 32'h001F_FFFF);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            7, 8, 9, 10:     v = last_err_sent + delta;
            11, 12:          v = last_err_sent;
            13, 14, 15, 16, 17: v = $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = ERR_MAX;
                    1:       v = ERR_MIN;
                    2:       v = '0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Register write as a setup phase and an access phase, then an idle bus
    // phase, entered and left at a rising edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Offers one error transaction after a random idle gap and holds it until
    // the block takes it. On acceptance the expected result is queued,
    // either the one given by the caller or the predictor's.
    task automatic send_error(input logic signed [ERR_W-1:0] err,
                              input logic known,
                              input logic signed [ERR_W-1:0] drive,
                              input logic sat);
        t_drive_result want;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_error_in <= err;
        do @(posedge i_clk); while (!o_in_ready);
        want = pid_predict_step(err);
        if (known) begin
            want.drive = drive;
            want.sat   = sat;
        end
        drive_expect_q.push_back(want);
        last_err_sent = err;
    endtask

    // Stops offering and waits for every owed result, so that registers can
    // be written while the block is idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: checks each accepted result against the oldest expectation
    // and chooses ready for the next cycle. A requested long hold-off is
    // counted here, one cycle at a time.
    always @(posedge i_clk) begin : drive_sink
        t_drive_result want;
        if (o_out_valid && i_out_ready) begin
            if (drive_expect_q.size() == 0) begin
                if (mismatch_cnt < MAX_SHOWN)
                    $display("ERROR: unexpected result drive=%h sat=%b",
                             o_drive_out, o_out_saturated);
                mismatch_cnt++;
            end else begin
                want = drive_expect_q.pop_front();
                if (o_drive_out !== want.drive || o_out_saturated !== want.sat) begin
                    if (mismatch_cnt < MAX_SHOWN)
                        $display("ERROR: drive expected %h sat %b, got drive %h sat %b",
                                 want.drive, want.sat, o_drive_out, o_out_saturated);
                    mismatch_cnt++;
                end
            end
        end

        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (long_hold_go) begin
            long_hold_go = 1'b0;
            i_out_ready <= 1'b0;
            hold_left   <= LONG_HOLD;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_error_in <= '0;
        i_out_ready <= 1'b0;
        cfg_prop       = '0;
        cfg_integ      = '0;
        cfg_deriv      = '0;
        cfg_period     = '0;
        cfg_integ_lim  = '0;
        cfg_deriv_lim  = '0;
        integ_state    = '0;
        prev_err_state = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with a slow sender and a slower receiver.
        snd_idle_pct = 26;
        rcv_idle_pct = 64;
        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_ROWS[r].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].value);
            end else begin
                send_error(DIR_ROWS[r].value, DIR_ROWS[r].known,
                           DIR_ROWS[r].exp_drive, DIR_ROWS[r].exp_sat);
            end
        end

        // Random part. Each pair of phases keeps one idle pattern: a slow
        // receiver, then a slow sender, then full rate on both sides. The
        // first phase runs every register at the top of its range.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph / 2)
                0: begin
                    snd_idle_pct = 26;
                    rcv_idle_pct = 64;
                end
                1: begin
                    snd_idle_pct = 64;
                    rcv_idle_pct = 26;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                write_reg(REG_PROP_GAIN,   PROP_GAIN_TOP);
                write_reg(REG_INTEG_GAIN,  FRAC_REG_TOP);
                write_reg(REG_DERIV_GAIN,  FRAC_REG_TOP);
                write_reg(REG_STEP_PERIOD, FRAC_REG_TOP);
                write_reg(REG_INTEG_LIMIT, FRAC_REG_TOP);
                write_reg(REG_DERIV_LIMIT, FRAC_REG_TOP);
            end else begin
                write_reg(REG_PROP_GAIN,   pick_reg_value(PROP_GAIN_TOP));
                write_reg(REG_INTEG_GAIN,  pick_reg_value(FRAC_REG_TOP));
                write_reg(REG_DERIV_GAIN,  pick_reg_value(FRAC_REG_TOP));
                write_reg(REG_STEP_PERIOD, pick_reg_value(FRAC_REG_TOP));
                write_reg(REG_INTEG_LIMIT, pick_reg_value(FRAC_REG_TOP));
                write_reg(REG_DERIV_LIMIT, pick_reg_value(FRAC_REG_TOP));
                if ($urandom_range(0, 2) == 0)
                    write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                              $urandom);
            end
            // With the sender at full rate, a long receiver hold-off fills
            // the block and must stall its input.
            if (ph == 4) long_hold_go = 1'b1;
            repeat (PHASE_ITEMS) send_error(next_error_sample(), 1'b0, '0, 1'b0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
design/pidc_pkg.sv
design/pidc_mul.sv
design/pidc_div.sv
design/pid_controller_clamped.sv
bench/tb_pid_controller_clamped.sv
